@@ hw/rtl/temperature_alarm_indicator_assert.svh @@
// Assertion macros for the temperature alarm indicator checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef TEMPERATURE_ALARM_INDICATOR_ASSERT_SVH
`define TEMPERATURE_ALARM_INDICATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TAI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TAI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define TAI_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/tai_pkg.sv @@
// Package for the temperature alarm indicator: widths, reset values,
// register indexes, LED patterns and the packed item layouts. No dependencies.
package tai_pkg;

   localparam int TEMP_FRAC_BITS = 4;

   localparam int TEMP_IN_W  = 14;
   localparam int TEMP_W     = 13;
   localparam int THR_W      = 8;
   localparam int DEB_W      = 8;
   localparam int BLINK_W    = 16;
   localparam int STEP_W     = 6;
   localparam int BAND_W     = 12;
   localparam int LED_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam int SCALED_W = THR_W + TEMP_FRAC_BITS;
   localparam int CMP_W    = ((SCALED_W > TEMP_W) ? SCALED_W : TEMP_W) + 2;

   localparam logic signed [TEMP_IN_W-1:0] TEMP_IN_MAX =
      TEMP_IN_W'((1 <<< (TEMP_W - 1)) - 1);
   localparam logic signed [TEMP_IN_W-1:0] TEMP_IN_MIN =
      TEMP_IN_W'(-(1 <<< (TEMP_W - 1)));

   localparam logic [DEB_W-1:0]   DEB_RESET   = DEB_W'(150);
   localparam logic [BLINK_W-1:0] BLINK_RESET = BLINK_W'(250);
   localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(5);
   localparam logic [BAND_W-1:0]  BAND4_RESET = BAND_W'(32);
   localparam logic [BAND_W-1:0]  BAND3_RESET = BAND_W'(160);
   localparam logic [BAND_W-1:0]  BAND2_RESET = BAND_W'(240);
   localparam logic [BAND_W-1:0]  BAND1_RESET = BAND_W'(320);
   localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(25);

   localparam logic [LED_W-1:0] LED_NONE  = 4'h0;
   localparam logic [LED_W-1:0] LED_ONE   = 4'h1;
   localparam logic [LED_W-1:0] LED_TWO   = 4'h3;
   localparam logic [LED_W-1:0] LED_THREE = 4'h7;
   localparam logic [LED_W-1:0] LED_ALL   = 4'hF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEBOUNCE   = 3'd0,
      CSR_BLINK      = 3'd1,
      CSR_STEP       = 3'd2,
      CSR_BAND_FOUR  = 3'd3,
      CSR_BAND_THREE = 3'd4,
      CSR_BAND_TWO   = 3'd5,
      CSR_BAND_ONE   = 3'd6
   } csr_index_type;

   // Request tdata, lowest bit first: raise_edge, lower_edge, temperature.
   typedef struct packed {
      logic signed [TEMP_IN_W-1:0] temperature;
      logic                        lower_edge;
      logic                        raise_edge;
   } req_data_type;

   // Response tdata, lowest bit first: led_bar, buzzer_on, threshold_now, pad.
   typedef struct packed {
      logic [RSP_DATA_W-THR_W-1-LED_W-1:0] pad;
      logic [THR_W-1:0]                    threshold_now;
      logic                                buzzer_on;
      logic [LED_W-1:0]                    led_bar;
   } rsp_data_type;

endpackage

@@ hw/rtl/tai_debounce.sv @@
// Debounce filter for one button: saturating quiet counter and edge accept.
// Depends on tai_pkg.
module tai_debounce (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      edge_seen,
   input  logic [tai_pkg::DEB_W-1:0] debounce_ticks,
   output logic                      accept
);
   import tai_pkg::*;

   logic [DEB_W-1:0] count_ff;
   logic [DEB_W-1:0] count_in;
   logic [DEB_W-1:0] count_inc;

   // count includes the current tick, sticks at all ones
   assign count_inc = (&count_ff) ? count_ff : count_ff + DEB_W'(1);
   assign accept    = edge_seen && (count_inc > debounce_ticks);
   assign count_in  = accept ? '0 : count_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (advance) begin
         count_ff <= count_in;
      end
   end

endmodule

@@ hw/rtl/temperature_alarm_indicator.sv @@
// Top level of the temperature alarm indicator.
// Depends on tai_pkg and tai_debounce.
//
// Usage:
//  - req_* carries one item per millisecond tick: button edges and the
//    temperature in tdata, sample_valid in tuser. rsp_* returns exactly one
//    item per request item: LED bar, buzzer drive and the current threshold.
//  - csr_* writes the seven setup registers (debounce, blink period, step,
//    four band margins) by index; write only while no item is in flight.
//  - Path: each item passes the input register, then the result register,
//    before rsp_tvalid rises with its result. Throughput: one item per
//    cycle while the response side does not stall; each item's update is a
//    single pass of compares and small adds.
//  - Reset: synchronous, active high. Registers return to their defaults,
//    the threshold to 25 degrees, counters and LED/buzzer state to zero,
//    and both channels empty.
//  - Back-pressure: while rsp_tready is low the result register holds its
//    item; one more item still enters the input register, then req_tready
//    drops until the response is taken. No item is lost or duplicated.
module temperature_alarm_indicator (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [0] raise_edge, [1] lower_edge, [15:2] temperature (signed, 1/16 deg)
   input  logic [tai_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] sample_valid
   input  logic                           req_tuser,
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [3:0] led_bar, [4] buzzer_on, [12:5] threshold_now, [15:13] zero
   output logic [tai_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // configuration write port
   input  logic                           csr_we,
   input  logic [tai_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tai_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tai_pkg::*;

   // setup registers
   logic [DEB_W-1:0]   debounce_ticks_ff;
   logic [BLINK_W-1:0] blink_ticks_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [BAND_W-1:0]  band_four_ff;
   logic [BAND_W-1:0]  band_three_ff;
   logic [BAND_W-1:0]  band_two_ff;
   logic [BAND_W-1:0]  band_one_ff;

   // input stage
   logic         item_valid_ff;
   req_data_type item_ff;
   logic         sample_ff;

   // block state
   logic signed [TEMP_W-1:0] temp_ff;
   logic signed [TEMP_W-1:0] temp_in;
   logic [THR_W-1:0]         thr_ff;
   logic [THR_W-1:0]         thr_in;
   logic [BLINK_W-1:0]       elapsed_ff;
   logic [BLINK_W-1:0]       elapsed_in;
   logic                     level_ff;
   logic                     level_in;
   logic [LED_W-1:0]         led_ff;
   logic [LED_W-1:0]         led_in;
   logic                     buzzer_ff;
   logic                     buzzer_in;

   // result stage
   logic         rsp_valid_ff;
   rsp_data_type rsp_ff;
   rsp_data_type rsp_in;

   // datapath
   logic                     advance;
   logic                     step_item;
   logic                     raise_acc;
   logic                     lower_acc;
   logic [THR_W:0]           raise_sum;
   logic [THR_W-1:0]         thr_raised;
   logic [THR_W-1:0]         step_ext;
   logic signed [TEMP_W-1:0] temp_sat;
   logic [SCALED_W-1:0]      thr_scaled;
   logic signed [CMP_W-1:0]  thr_cmp;
   logic signed [CMP_W-1:0]  temp_cmp;
   logic signed [CMP_W-1:0]  diff;
   logic [BLINK_W-1:0]       elapsed_inc;
   logic [LED_W-1:0]         bar;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= DEB_RESET;
         blink_ticks_ff    <= BLINK_RESET;
         step_ff           <= STEP_RESET;
         band_four_ff      <= BAND4_RESET;
         band_three_ff     <= BAND3_RESET;
         band_two_ff       <= BAND2_RESET;
         band_one_ff       <= BAND1_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:   debounce_ticks_ff <= csr_wdata[DEB_W-1:0];
            CSR_BLINK:      blink_ticks_ff    <= csr_wdata[BLINK_W-1:0];
            CSR_STEP:       step_ff           <= csr_wdata[STEP_W-1:0];
            CSR_BAND_FOUR:  band_four_ff      <= csr_wdata[BAND_W-1:0];
            CSR_BAND_THREE: band_three_ff     <= csr_wdata[BAND_W-1:0];
            CSR_BAND_TWO:   band_two_ff       <= csr_wdata[BAND_W-1:0];
            CSR_BAND_ONE:   band_one_ff       <= csr_wdata[BAND_W-1:0];
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // ---------------- handshake ----------------
   // the result register frees up when empty or being drained this cycle
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step_item  = item_valid_ff && advance;
   assign req_tready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_tready) begin
            item_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= item_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff   <= req_data_type'(req_tdata);
         sample_ff <= req_tuser;
      end
   end

   // ---------------- buttons ----------------
   tai_debounce u_raise_db (
      .clock          (clock),
      .reset          (reset),
      .advance        (step_item),
      .edge_seen      (item_ff.raise_edge),
      .debounce_ticks (debounce_ticks_ff),
      .accept         (raise_acc)
   );

   tai_debounce u_lower_db (
      .clock          (clock),
      .reset          (reset),
      .advance        (step_item),
      .edge_seen      (item_ff.lower_edge),
      .debounce_ticks (debounce_ticks_ff),
      .accept         (lower_acc)
   );

   // raise first, saturating at 255; then lower, flooring at 0
   assign step_ext   = THR_W'(step_ff);
   assign raise_sum  = {1'b0, thr_ff} + {1'b0, step_ext};
   assign thr_raised = !raise_acc ? thr_ff :
                       (raise_sum[THR_W] ? '1 : raise_sum[THR_W-1:0]);

   always_comb begin
      thr_in = thr_raised;
      if (lower_acc) begin
         thr_in = (thr_raised > step_ext) ? thr_raised - step_ext : '0;
      end
   end

   // ---------------- sample evaluation ----------------
   always_comb begin
      priority if (item_ff.temperature > TEMP_IN_MAX) begin
         temp_sat = TEMP_W'(TEMP_IN_MAX);
      end else if (item_ff.temperature < TEMP_IN_MIN) begin
         temp_sat = TEMP_W'(TEMP_IN_MIN);
      end else begin
         temp_sat = TEMP_W'(item_ff.temperature);
      end
   end

   // threshold in the same fixed-point units as the sample
   assign thr_scaled = {thr_in, {TEMP_FRAC_BITS{1'b0}}};
   assign thr_cmp    = signed'(CMP_W'(thr_scaled));
   assign temp_cmp   = CMP_W'(temp_sat);
   assign diff       = thr_cmp - temp_cmp;

   assign elapsed_inc = (&elapsed_ff) ? elapsed_ff : elapsed_ff + BLINK_W'(1);

   // proximity bar: first band (four..one) whose margin covers the gap
   always_comb begin
      priority if (diff <= signed'(CMP_W'(band_four_ff))) begin
         bar = LED_ALL;
      end else if (diff <= signed'(CMP_W'(band_three_ff))) begin
         bar = LED_THREE;
      end else if (diff <= signed'(CMP_W'(band_two_ff))) begin
         bar = LED_TWO;
      end else if (diff <= signed'(CMP_W'(band_one_ff))) begin
         bar = LED_ONE;
      end else begin
         bar = LED_NONE;
      end
   end

   always_comb begin
      temp_in    = temp_ff;
      elapsed_in = elapsed_inc;
      level_in   = level_ff;
      led_in     = led_ff;
      buzzer_in  = buzzer_ff;
      if (sample_ff) begin
         temp_in   = temp_sat;
         buzzer_in = temp_cmp > thr_cmp;
         if (temp_cmp >= thr_cmp) begin
            // alarm reached: blink all LEDs together
            if (elapsed_inc >= blink_ticks_ff) begin
               level_in   = !level_ff;
               led_in     = level_ff ? LED_NONE : LED_ALL;
               elapsed_in = '0;
            end
         end else begin
            led_in = bar;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff    <= '0;
         thr_ff     <= THR_RESET;
         elapsed_ff <= '0;
         level_ff   <= 1'b0;
         led_ff     <= '0;
         buzzer_ff  <= 1'b0;
      end else if (step_item) begin
         temp_ff    <= temp_in;
         thr_ff     <= thr_in;
         elapsed_ff <= elapsed_in;
         level_ff   <= level_in;
         led_ff     <= led_in;
         buzzer_ff  <= buzzer_in;
      end
   end

   // ---------------- result register ----------------
   // temp_ff is kept as part of the block state; it mirrors the last sample
   always_comb begin
      rsp_in               = '0;
      rsp_in.led_bar       = led_in;
      rsp_in.buzzer_on     = buzzer_in;
      rsp_in.threshold_now = thr_in;
      rsp_in.pad           = '0;
   end

   always_ff @(posedge clock) begin
      if (step_item) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

@@ hw/rtl/tai_checker.sv @@
// Port-level checker for the temperature alarm indicator, bound to the top.
// Depends on tai_pkg and temperature_alarm_indicator_assert.svh.
`include "temperature_alarm_indicator_assert.svh"

module tai_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tai_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tai_pkg::*;

   logic [LED_W-1:0] led;

   assign led = rsp_tdata[LED_W-1:0];

   // a stalled response stays put
   `TAI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // LEDs only ever show a bar or the blink pattern
   `TAI_ASSERT_NOW(a_led_pattern, clock, reset, rsp_tvalid, led == LED_NONE || led == LED_ONE || led == LED_TWO || led == LED_THREE || led == LED_ALL, "illegal LED pattern")

   // request side only stalls when the response side is stalled
   `TAI_ASSERT_NOW(a_ready_cause, clock, reset, !req_tready, rsp_tvalid && !rsp_tready, "request stalled without downstream stall")

   // reset empties the response channel
   `TAI_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "response valid after reset")

endmodule

bind temperature_alarm_indicator tai_checker u_tai_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
